FILE: rtl/core/assert_macros.svh
// Assertion macros, used by the top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/core/lcg_pkg.sv
// Shared types and constants of the combination generator.
package lcg_pkg;

  localparam int SET_W    = 9;
  localparam int CHOOSE_W = 5;
  localparam int POS_W    = 4;
  localparam int VAL_W    = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam int DEF_MAX_CHOOSE = 16;
  localparam int DEF_MAX_SET    = 256;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHOOSE_COUNT = 1'd1;

  // element value reported for an empty combination
  localparam logic signed [VAL_W-1:0] VAL_NONE = -9'sd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZERO,
    ST_CHECK,
    ST_EMIT,
    ST_SCAN,
    ST_FILL
  } lcg_state_e;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_CLR,
    CNT_INC,
    CNT_DEC,
    CNT_LAST
  } cnt_op_e;

  typedef struct packed {
    cnt_op_e cnt_op;
    logic    rd_en;
    logic    wrap_capture;
    logic    adv;
    logic    out_load;
    logic    out_load_zero;
    logic    grow_capture;
    logic    fill;
    logic    clear_valid;
  } lcg_cmd_t;

  typedef struct packed {
    logic out_free;
    logic r_zero;
    logic cnt_last;
    logic cnt_zero;
    logic can_grow;
    logic wrap;
  } lcg_stat_t;

endpackage

FILE: rtl/core/lexicographic_combination_generator.sv
// Lexicographic r-of-n combination generator, top level. Each accepted request
// streams the current combination as r results in ascending position order,
// the last one marked, and with advance set then steps to the next combination
// in lexicographic order, wrapping to 0..r-1 after the final one (the wrap flag
// rides on every result of that request). With r zero one result of value -1
// comes out. Per request: the first element is fetched and the wrap flag
// settled, then one result per cycle while the output is not stalled; an
// advancing request then scans down for the rightmost element that can grow
// and refills the elements to its right. Configuration writes reload the
// start combination at once through per-entry valid bits; there is no
// clearing pass.
`include "assert_macros.svh"

module lexicographic_combination_generator import lcg_pkg::*; #(
  parameter int MAX_CHOOSE = DEF_MAX_CHOOSE,
  parameter int MAX_SET    = DEF_MAX_SET
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    advance_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [POS_W-1:0]        position_o,
  output logic signed [VAL_W-1:0] element_value_o,
  output logic                    last_element_o,
  output logic                    wrapped_o
);

  lcg_cmd_t  cmd;
  lcg_stat_t stat;

  assign cfg_ready_o = 1'b1;

  lcg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .advance_i  (advance_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lcg_dpath #(
    .MAX_CHOOSE (MAX_CHOOSE),
    .MAX_SET    (MAX_SET)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_write_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .position_o      (position_o),
    .element_value_o (element_value_o),
    .last_element_o  (last_element_o),
    .wrapped_o       (wrapped_o)
  );

  // a request keeps the block busy for at least the following cycle
  `ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o)
  // a result is only written into a free output register
  `ASSERT_IMPL(a_load_when_free, cmd.out_load || cmd.out_load_zero, stat.out_free)
  // the store is never written and read in the same cycle
  `ASSERT_IMPL(a_fill_no_read, cmd.fill, !cmd.rd_en && !cmd.out_load)

endmodule

FILE: rtl/core/lcg_ctrl.sv
// Sequencer for the combination generator: check, emit, scan and refill.
module lcg_ctrl import lcg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      advance_i,
  output logic      in_stall_o,
  input  lcg_stat_t stat_i,
  output lcg_cmd_t  cmd_o
);

  lcg_state_e state_q, state_d;
  logic       adv_q, adv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      adv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      adv_q   <= adv_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    adv_d      = adv_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    cmd_o.cnt_op = CNT_HOLD;
    cmd_o.adv    = adv_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          adv_d = advance_i;
          if (stat_i.r_zero) begin
            state_d = ST_ZERO;
          end else begin
            // fetch the first element to decide the wrap flag up front
            cmd_o.cnt_op = CNT_CLR;
            cmd_o.rd_en  = 1'b1;
            state_d      = ST_CHECK;
          end
        end
      end
      ST_ZERO: begin
        if (stat_i.out_free) begin
          cmd_o.out_load_zero = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CHECK: begin
        cmd_o.wrap_capture = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (!stat_i.cnt_last) begin
            cmd_o.cnt_op = CNT_INC;
            cmd_o.rd_en  = 1'b1;
          end else if (stat_i.wrap) begin
            cmd_o.clear_valid = 1'b1;
            state_d = ST_IDLE;
          end else if (adv_q) begin
            cmd_o.cnt_op = CNT_LAST;
            cmd_o.rd_en  = 1'b1;
            state_d      = ST_SCAN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (stat_i.can_grow) begin
          cmd_o.grow_capture = 1'b1;
          state_d = ST_FILL;
        end else if (stat_i.cnt_zero) begin
          cmd_o.clear_valid = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.cnt_op = CNT_DEC;
          cmd_o.rd_en  = 1'b1;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (stat_i.cnt_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.cnt_op = CNT_INC;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/lcg_dpath.sv
// Datapath: config registers, element store, position counter, result register.
module lcg_dpath import lcg_pkg::*; #(
  parameter int MAX_CHOOSE = DEF_MAX_CHOOSE,
  parameter int MAX_SET    = DEF_MAX_SET
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_write_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  lcg_cmd_t                     cmd_i,
  output lcg_stat_t                    stat_o,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [POS_W-1:0]             position_o,
  output logic signed [VAL_W-1:0]      element_value_o,
  output logic                         last_element_o,
  output logic                         wrapped_o
);

  localparam int IDX_W  = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
  localparam int ELEM_W = (MAX_SET > 256) ? SET_W : $clog2(MAX_SET);
  localparam int NCAP_I = (MAX_SET > (2**SET_W) - 1) ? (2**SET_W) - 1 : MAX_SET;
  localparam int RCAP_I = (MAX_CHOOSE > (2**CHOOSE_W) - 1) ? (2**CHOOSE_W) - 1 : MAX_CHOOSE;
  localparam logic [SET_W-1:0]    N_CAP = SET_W'(NCAP_I);
  localparam logic [CHOOSE_W-1:0] R_CAP = CHOOSE_W'(RCAP_I);

  logic [SET_W-1:0]    set_size_q;
  logic [CHOOSE_W-1:0] choose_q;
  logic [SET_W-1:0]    n_eff;
  logic [CHOOSE_W-1:0] r_cap, r_eff;

  logic [ELEM_W-1:0]   mem_q [MAX_CHOOSE];
  logic [MAX_CHOOSE-1:0] valid_q;
  logic [ELEM_W-1:0]   rd_data_q;
  logic                rd_vld_q;
  logic [IDX_W-1:0]    rd_idx_q;
  logic [IDX_W-1:0]    rd_addr;
  logic [ELEM_W-1:0]   rd_val;
  logic [SET_W-1:0]    rd_val9;

  logic [CHOOSE_W-1:0] cnt_q, cnt_d;
  logic [SET_W-1:0]    v_q;
  logic                wrap_q;
  logic [SET_W-1:0]    top_first;
  logic [SET_W-1:0]    lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q <= SET_W'(1);
      choose_q   <= '0;
    end else if (cfg_write_i) begin
      if (cfg_index_i == CFG_SET_SIZE) begin
        set_size_q <= cfg_data_i[SET_W-1:0];
      end else if (cfg_index_i == CFG_CHOOSE_COUNT) begin
        choose_q <= cfg_data_i[CHOOSE_W-1:0];
      end
    end
  end

  always_comb begin
    if (set_size_q == '0) begin
      n_eff = SET_W'(1);
    end else if (set_size_q > N_CAP) begin
      n_eff = N_CAP;
    end else begin
      n_eff = set_size_q;
    end
    r_cap = (choose_q > R_CAP) ? R_CAP : choose_q;
    r_eff = (SET_W'(r_cap) > n_eff) ? CHOOSE_W'(n_eff) : r_cap;
  end

  always_comb begin
    unique case (cmd_i.cnt_op)
      CNT_HOLD: cnt_d = cnt_q;
      CNT_CLR:  cnt_d = '0;
      CNT_INC:  cnt_d = cnt_q + CHOOSE_W'(1);
      CNT_DEC:  cnt_d = cnt_q - CHOOSE_W'(1);
      CNT_LAST: cnt_d = r_eff - CHOOSE_W'(1);
      default:  cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign rd_addr = IDX_W'(cnt_d);

  // an entry without its valid bit reads as its start value, its own index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cfg_write_i || cmd_i.clear_valid) begin
      valid_q <= '0;
    end else if (cmd_i.fill) begin
      valid_q[IDX_W'(cnt_q)] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      mem_q[IDX_W'(cnt_q)] <= ELEM_W'(v_q);
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= valid_q[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  assign rd_val  = rd_vld_q ? rd_data_q : ELEM_W'(rd_idx_q);
  assign rd_val9 = SET_W'(rd_val);

  assign top_first = n_eff - SET_W'(r_eff);
  assign lim       = top_first + SET_W'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= 1'b0;
    end else if (cmd_i.wrap_capture) begin
      // the last combination is the one whose first element is n - r
      wrap_q <= cmd_i.adv && (rd_val9 == top_first);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grow_capture) begin
      v_q <= rd_val9 + SET_W'(1);
    end else if (cmd_i.fill) begin
      v_q <= v_q + SET_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load || cmd_i.out_load_zero) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      position_o      <= POS_W'(cnt_q);
      element_value_o <= $signed(rd_val9);
      last_element_o  <= stat_o.cnt_last;
      wrapped_o       <= wrap_q;
    end else if (cmd_i.out_load_zero) begin
      position_o      <= '0;
      element_value_o <= VAL_NONE;
      last_element_o  <= 1'b1;
      wrapped_o       <= 1'b0;
    end
  end

  always_comb begin
    stat_o.out_free = !out_valid_o || !out_stall_i;
    stat_o.r_zero   = (r_eff == '0);
    stat_o.cnt_last = (cnt_q == r_eff - CHOOSE_W'(1));
    stat_o.cnt_zero = (cnt_q == '0);
    stat_o.can_grow = (rd_val9 < lim);
    stat_o.wrap     = wrap_q;
  end

endmodule
